/* rtl/qpe_pkg.sv */
// Shared widths, function codes and constants of the quadrature pulse emulator.
`default_nettype none
package qpe_pkg;

  // Field and register widths
  localparam int FUNC_W       = 2;
  localparam int FREQ_W       = 16;
  localparam int PHASE_W      = 4;
  localparam int RATIO_W      = 24;
  localparam int MIN_PERIOD_W = 16;
  localparam int PERIOD_W     = 24;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 24;

  // Number of emulated sensors and slots on the port (two bits per slot)
  localparam int SENSORS   = 2;
  localparam int NUM_SLOTS = PHASE_W / 2;

  // Function codes of a request
  localparam logic [FUNC_W-1:0] FUNC_MESSAGE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TIMER    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_WATCHDOG = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_RATIO = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD  = 1'd1;

  // Reset values
  localparam logic [RATIO_W-1:0]      RESET_CLOCK_RATIO = 24'd4000000;
  localparam logic [MIN_PERIOD_W-1:0] RESET_MIN_PERIOD  = 16'd150;
  localparam logic [PERIOD_W-1:0]     RESET_STEP_PERIOD = 24'h005555;

  // Clockwise Gray sequence of one sensor
  localparam logic [1:0] GRAY_CW [4] = '{2'd0, 2'd1, 2'd3, 2'd2};

endpackage : qpe_pkg
`default_nettype wire

/* rtl/qpe_if.sv */
// Request and result channel interfaces of the quadrature pulse emulator.
`default_nettype none
interface qpe_req_if;
  import qpe_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [FREQ_W-1:0] freq_x16;
  logic              dir_cw_a;
  logic              dir_cw_b;
  logic              fault_a_ch1;
  logic              fault_a_ch2;
  logic              fault_b_ch1;
  logic              fault_b_ch2;

  modport source (
    output valid, func, freq_x16, dir_cw_a, dir_cw_b,
           fault_a_ch1, fault_a_ch2, fault_b_ch1, fault_b_ch2,
    input  ready
  );

  modport sink (
    input  valid, func, freq_x16, dir_cw_a, dir_cw_b,
           fault_a_ch1, fault_a_ch2, fault_b_ch1, fault_b_ch2,
    output ready
  );
endinterface : qpe_req_if

interface qpe_rsp_if;
  import qpe_pkg::*;

  logic               valid;
  logic               ready;
  logic [PHASE_W-1:0] phase_out;
  logic               emulating;
  logic               stepped;

  modport source (output valid, phase_out, emulating, stepped, input ready);
  modport sink   (input valid, phase_out, emulating, stepped, output ready);
endinterface : qpe_rsp_if
`default_nettype wire

/* rtl/quadrature_pulse_emulator_unit.sv */
// Quadrature pulse emulator: message decode, step period divider and phase sequencer.
//
// Usage:
//   cmd carries requests: a message (func 0), a timer tick (func 1) or a
//   watchdog tick (func 2). rsp returns exactly one result per request:
//   the emulated port value, the emulating flag and whether this tick stepped.
//   The user must write configuration (clock_ratio at index 0, min_period at index 1)
//   through cfg_we / cfg_index / cfg_data only while the block is idle; not enforced.
// Timing:
//   Timer ticks, watchdog ticks, repeated messages and stop messages leave the
//   block idle; the result is registered and shows in the cycle after accept.
//   A new message with a nonzero frequency starts a division: the period
//   quotient clock_ratio / freq_x16 comes from a restoring divider that
//   resolves one quotient bit per cycle. cmd.ready is low during the division.
//   Its result comes right away; after it the quotient applies if above min_period.
// Stall:
//   The result register holds while rsp.ready is low; a new request is taken
//   in the same cycle that the waiting result is taken, if the block is idle.
// Reset (rst, synchronous): emulation stopped, port zero, period 0x5555,
//   registers at 4000000 and 150.
`default_nettype none
module quadrature_pulse_emulator_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  qpe_req_if.sink                             cmd,
  qpe_rsp_if.source                           rsp,
  input  wire logic                           cfg_we,
  input  wire logic [qpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [qpe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import qpe_pkg::*;

  localparam int DIV_STEPS = RATIO_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic {ST_IDLE, ST_DIV} state_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [1:0]        dir_cw;
    logic [1:0]        fault_ch1;
    logic [1:0]        fault_ch2;
  } message_t;

  // Registers
  state_t                  state;
  logic [RATIO_W-1:0]      clock_ratio;
  logic [MIN_PERIOD_W-1:0] min_period;
  message_t                stored_message;
  logic [PHASE_W-1:0]      phase_table [4];
  logic [1:0]              step_index;
  logic [PHASE_W-1:0]      port_value;
  logic [PERIOD_W-1:0]     step_period;
  logic [PERIOD_W-1:0]     tick_count;
  logic                    running;
  logic                    message_seen;
  logic                    out_valid;
  logic                    out_emulating;
  logic                    out_stepped;
  logic [RATIO_W-1:0]      div_quo;
  logic [FREQ_W-1:0]       div_rem;
  logic [FREQ_W-1:0]       div_divisor;
  logic [DIV_CNT_W-1:0]    div_cnt;

  // Combinational
  logic                    accept;
  message_t                msg_in;
  logic                    msg_changed;
  logic                    msg_start;
  logic                    running_next;
  logic [PHASE_W-1:0]      table_next [4];
  logic [PERIOD_W:0]       tick_inc;
  logic                    tick_step;
  logic [FREQ_W:0]         div_shifted;
  logic [FREQ_W:0]         div_diff;
  logic                    div_take;
  logic [RATIO_W-1:0]      div_quo_next;

  assign cmd.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign accept    = cmd.valid && cmd.ready;

  assign rsp.valid     = out_valid;
  assign rsp.phase_out = port_value;
  assign rsp.emulating = out_emulating;
  assign rsp.stepped   = out_stepped;

  // Message packing and change detection
  always_comb begin
    msg_in.freq      = cmd.freq_x16;
    msg_in.dir_cw    = {cmd.dir_cw_b, cmd.dir_cw_a};
    msg_in.fault_ch1 = {cmd.fault_b_ch1, cmd.fault_a_ch1};
    msg_in.fault_ch2 = {cmd.fault_b_ch2, cmd.fault_a_ch2};
  end

  assign msg_changed = (msg_in != stored_message);
  assign msg_start   = msg_changed && (msg_in.freq != '0);

  // Emulating flag after the accepted request
  always_comb begin
    running_next = running;
    if (accept) begin
      case (cmd.func)
        FUNC_MESSAGE: begin
          if (msg_changed) begin
            running_next = msg_start;
          end
        end
        FUNC_WATCHDOG: begin
          if (!message_seen) begin
            running_next = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Phase table of the incoming message: Gray walk per sensor, faulted bits low
  always_comb begin
    logic [1:0] code;
    logic [1:0] gidx;
    for (int i = 0; i < 4; i++) begin
      table_next[i] = '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        gidx = msg_in.dir_cw[s] ? 2'(i) : (2'(i) ^ 2'b11);
        code = GRAY_CW[gidx];
        if (msg_in.fault_ch1[s]) begin
          code = code & 2'b10;
        end
        if (msg_in.fault_ch2[s]) begin
          code = code & 2'b01;
        end
        if (s < SENSORS) begin
          table_next[i][2*s +: 2] = code;
        end
      end
    end
  end

  // Timer compare
  assign tick_inc  = {1'b0, tick_count} + (PERIOD_W+1)'(1);
  assign tick_step = running && (tick_inc >= {1'b0, step_period});

  // Restoring divider step: one quotient bit per cycle
  assign div_shifted  = {div_rem, div_quo[RATIO_W-1]};
  assign div_diff     = div_shifted - {1'b0, div_divisor};
  assign div_take     = (div_shifted >= {1'b0, div_divisor});
  assign div_quo_next = {div_quo[RATIO_W-2:0], div_take};

  // Sequencer, state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      clock_ratio    <= RESET_CLOCK_RATIO;
      min_period     <= RESET_MIN_PERIOD;
      stored_message <= '0;
      for (int i = 0; i < 4; i++) begin
        phase_table[i] <= '0;
      end
      step_index     <= '0;
      port_value     <= '0;
      step_period    <= RESET_STEP_PERIOD;
      tick_count     <= '0;
      running        <= 1'b0;
      message_seen   <= 1'b0;
      out_valid      <= 1'b0;
      out_emulating  <= 1'b0;
      out_stepped    <= 1'b0;
      div_cnt        <= '0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CLOCK_RATIO: clock_ratio <= cfg_data[RATIO_W-1:0];
          REG_MIN_PERIOD:  min_period  <= cfg_data[MIN_PERIOD_W-1:0];
          default: ;
        endcase
      end

      // result register fills on accept, drains when taken
      out_valid <= accept || (out_valid && !rsp.ready);

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            out_emulating <= running_next;
            out_stepped   <= (cmd.func == FUNC_TIMER) && tick_step;
            case (cmd.func)
              FUNC_MESSAGE: begin
                message_seen <= 1'b1;
                if (msg_changed) begin
                  stored_message <= msg_in;
                  if (msg_start) begin
                    for (int i = 0; i < 4; i++) begin
                      phase_table[i] <= table_next[i];
                    end
                    tick_count    <= '0;
                    running       <= 1'b1;
                    div_quo       <= clock_ratio;
                    div_rem       <= '0;
                    div_divisor   <= msg_in.freq;
                    div_cnt       <= '0;
                    state         <= ST_DIV;
                  end else begin
                    running       <= 1'b0;
                  end
                end
              end
              FUNC_TIMER: begin
                if (tick_step) begin
                  port_value  <= phase_table[step_index];
                  step_index  <= step_index + 2'd1;
                  tick_count  <= '0;
                end else if (running) begin
                  tick_count <= tick_inc[PERIOD_W-1:0];
                end
              end
              FUNC_WATCHDOG: begin
                if (!message_seen) begin
                  running       <= 1'b0;
                end
                message_seen <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          div_quo <= div_quo_next;
          div_rem <= div_take ? div_diff[FREQ_W-1:0] : div_shifted[FREQ_W-1:0];
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            if (div_quo_next > {{(RATIO_W-MIN_PERIOD_W){1'b0}}, min_period}) begin
              step_period <= div_quo_next;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule : quadrature_pulse_emulator_unit
`default_nettype wire
